>>> design/rlcs_pkg.sv
// rlcs_pkg: shared types and constants for the RGB LED chain serializer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rlcs_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_BIT_PERIOD = 3'd0;
   localparam logic [2:0] REG_ZERO_HIGH  = 3'd1;
   localparam logic [2:0] REG_ONE_HIGH   = 3'd2;
   localparam logic [2:0] REG_BRIGHTNESS = 3'd3;
   localparam logic [2:0] REG_PIXEL_CNT  = 3'd4;

   // reset values of the timing registers
   localparam logic [15:0] BIT_PERIOD_RST = 16'd277;
   localparam logic [15:0] ZERO_HIGH_RST  = 16'd89;
   localparam logic [15:0] ONE_HIGH_RST   = 16'd185;
   localparam logic [7:0]  BRIGHT_RST     = 8'd255;

   // last bit position of the 24-bit color word
   localparam logic [4:0] LAST_BIT = 5'd23;

   // item class handed from front to back
   typedef enum logic {
      FUNC_TICK  = 1'b0,
      FUNC_WRITE = 1'b1
   } func_type;

   // one queue entry: classified item with its packed GRB word
   typedef struct packed {
      func_type    func;
      logic [23:0] grb;
   } entry_type;

   // bit timing settings seen by the back end
   typedef struct packed {
      logic [15:0] bit_period;
      logic [15:0] zero_high;
      logic [15:0] one_high;
   } timing_type;

endpackage

>>> design/rgb_led_chain_serializer.sv
// rgb_led_chain_serializer: top level with configuration registers.
// Depends on rlcs_pkg, rlcs_front, rlcs_queue and rlcs_back.
`timescale 1ns / 1ps

//  channel | direction | signals
//  req_    | in        | func, red, green, blue (valid/ready)
//  rsp_    | out       | line_level, busy_res (valid/ready)
//  csr_    | in        | index, data (valid/ready, always ready)
//
// One item per cycle while results are taken; each item passes from the front
// into the two-entry queue, then through the timing engine into the result
// register. Reset clears the queue, the transmit state and the registers to
// their defaults. Result stalls fill the queue and then drop req_ready.

module rgb_led_chain_serializer #(
   parameter int MAX_PIXELS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_line_level,
   output logic        rsp_busy_res,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int PIX_W = $clog2(MAX_PIXELS + 1);

   rlcs_pkg::timing_type timing_ff;
   logic [7:0]           bright_ff;
   logic [PIX_W-1:0]     chain_ff;
   logic [31:0]          pix_req;
   logic [31:0]          pix_clamp;
   logic                 csr_write;
   logic                 push_valid;
   logic                 push_ready;
   rlcs_pkg::entry_type  push_entry;
   logic                 pop_valid;
   logic                 pop_ready;
   rlcs_pkg::entry_type  pop_entry;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // chain length: zero counts as one, capped at the maximum
   always_comb begin
      pix_req   = 32'(csr_data[10:0]);
      pix_clamp = pix_req;
      if (pix_req == 32'd0) begin
         pix_clamp = 32'd1;
      end else if (pix_req > 32'(MAX_PIXELS)) begin
         pix_clamp = 32'(MAX_PIXELS);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.bit_period <= rlcs_pkg::BIT_PERIOD_RST;
         timing_ff.zero_high  <= rlcs_pkg::ZERO_HIGH_RST;
         timing_ff.one_high   <= rlcs_pkg::ONE_HIGH_RST;
         bright_ff            <= rlcs_pkg::BRIGHT_RST;
         chain_ff             <= PIX_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            rlcs_pkg::REG_BIT_PERIOD: timing_ff.bit_period <= csr_data;
            rlcs_pkg::REG_ZERO_HIGH:  timing_ff.zero_high  <= csr_data;
            rlcs_pkg::REG_ONE_HIGH:   timing_ff.one_high   <= csr_data;
            rlcs_pkg::REG_BRIGHTNESS: bright_ff            <= csr_data[7:0];
            rlcs_pkg::REG_PIXEL_CNT:  chain_ff             <= pix_clamp[PIX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   rlcs_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .brightness (bright_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   rlcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   rlcs_back #(
      .PIX_W (PIX_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .timing         (timing_ff),
      .chain_len      (chain_ff),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_entry      (pop_entry),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_line_level (rsp_line_level),
      .rsp_busy_res   (rsp_busy_res)
   );

endmodule

>>> design/rlcs_front.sv
// rlcs_front: accepts request items, classifies them and scales the color.
// Depends on rlcs_pkg; pushes into rlcs_queue.
`timescale 1ns / 1ps

module rlcs_front (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [7:0]         req_red,
   input  logic [7:0]         req_green,
   input  logic [7:0]         req_blue,
   input  logic [7:0]         brightness,
   output logic               push_valid,
   input  logic               push_ready,
   output rlcs_pkg::entry_type push_entry
);

   logic [15:0] red_prod;
   logic [15:0] green_prod;
   logic [15:0] blue_prod;

   // scale each channel: (c * brightness) >> 8
   assign red_prod   = 16'(req_red)   * 16'(brightness);
   assign green_prod = 16'(req_green) * 16'(brightness);
   assign blue_prod  = 16'(req_blue)  * 16'(brightness);

   // pack as green, red, blue with green on top
   always_comb begin
      push_entry.func = req_func ? rlcs_pkg::FUNC_WRITE : rlcs_pkg::FUNC_TICK;
      push_entry.grb  = {green_prod[15:8], red_prod[15:8], blue_prod[15:8]};
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

>>> design/rlcs_queue.sv
// rlcs_queue: two-entry queue between front and back end.
// Depends on rlcs_pkg for the entry type.
`timescale 1ns / 1ps

module rlcs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  rlcs_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output rlcs_pkg::entry_type pop_entry
);

   rlcs_pkg::entry_type mem_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> design/rlcs_back.sv
// rlcs_back: bit timing engine and result register.
// Depends on rlcs_pkg; pops items from rlcs_queue.
`timescale 1ns / 1ps

module rlcs_back #(
   parameter int PIX_W = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rlcs_pkg::timing_type timing,
   input  logic [PIX_W-1:0]     chain_len,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  rlcs_pkg::entry_type  pop_entry,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_line_level,
   output logic                 rsp_busy_res
);

   logic [23:0]      word_ff, word_in;
   logic [4:0]       bit_ff, bit_in;
   logic [15:0]      tick_ff, tick_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic             sending_ff, sending_in;
   logic             valid_ff, valid_in;
   logic             level_ff, level_in;
   logic             busy_ff, busy_in;
   logic             step;
   logic             start;
   logic             wrap;
   logic [PIX_W-1:0] pix_next;
   logic             cur_bit;
   logic [15:0]      high_time;

   // take an item when the result register is free or being drained
   assign pop_ready = !valid_ff || rsp_ready;
   assign step      = pop_valid && pop_ready;
   assign start     = (pop_entry.func == rlcs_pkg::FUNC_WRITE) && !sending_ff;
   assign wrap      = ({1'b0, tick_ff} + 17'd1) >= {1'b0, timing.bit_period};
   assign pix_next  = pix_ff + PIX_W'(1);

   // transmit state advance
   always_comb begin
      word_in    = word_ff;
      bit_in     = bit_ff;
      tick_in    = tick_ff;
      pix_in     = pix_ff;
      sending_in = sending_ff;
      if (step) begin
         if (start) begin
            word_in    = pop_entry.grb;
            bit_in     = 5'd0;
            tick_in    = 16'd0;
            pix_in     = '0;
            sending_in = 1'b1;
         end else if (sending_ff) begin
            if (wrap) begin
               tick_in = 16'd0;
               if (bit_ff == rlcs_pkg::LAST_BIT) begin
                  bit_in = 5'd0;
                  if (pix_next >= chain_len) begin
                     pix_in     = '0;
                     sending_in = 1'b0;
                  end else begin
                     pix_in = pix_next;
                  end
               end else begin
                  bit_in = bit_ff + 5'd1;
               end
            end else begin
               tick_in = tick_ff + 16'd1;
            end
         end
      end
   end

   // line level after the step, MSB first
   always_comb begin
      cur_bit   = word_in[rlcs_pkg::LAST_BIT - bit_in];
      high_time = cur_bit ? timing.one_high : timing.zero_high;
      level_in  = sending_in && (tick_in < high_time);
      busy_in   = sending_in;
      valid_in  = step || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff    <= 24'd0;
         bit_ff     <= 5'd0;
         tick_ff    <= 16'd0;
         pix_ff     <= '0;
         sending_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         word_ff    <= word_in;
         bit_ff     <= bit_in;
         tick_ff    <= tick_in;
         pix_ff     <= pix_in;
         sending_ff <= sending_in;
         valid_ff   <= valid_in;
      end
   end

   // result payload, loaded with each item
   always_ff @(posedge clock) begin
      if (step) begin
         level_ff <= level_in;
         busy_ff  <= busy_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_line_level = level_ff;
   assign rsp_busy_res   = busy_ff;

endmodule

>>> sim/rlcs_checker.sv
// rlcs_checker: predicts the LED data line level and busy flag for every item
// and compares each delivered result in order. Depends on rlcs_pkg.
`timescale 1ns / 1ps

module rlcs_checker #(
   parameter int MAX_PIXELS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_line_level,
   input  logic        rsp_busy_res,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          mismatch_count,
   output int          pending_results,
   output int          chains_started
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic level;
      logic busy;
   } line_sample_type;

   // shadow copies of the timing, brightness and pixel count registers
   logic [15:0] period_cfg;
   logic [15:0] zero_high_cfg;
   logic [15:0] one_high_cfg;
   logic [7:0]  bright_cfg;
   logic [10:0] pixels_cfg;

   // transmit position
   logic [23:0] grb_word;
   int unsigned bit_pos;
   int unsigned tick_pos;
   int unsigned pixel_pos;
   logic        sending;

   line_sample_type line_queue[$];

   function automatic logic [7:0] dim(input logic [7:0] c);
      logic [15:0] prod;
      prod = 16'(c) * 16'(bright_cfg);
      return prod[15:8];
   endfunction

   // zero pixels acts as one, anything above the chain limit saturates
   function automatic int unsigned chain_len();
      int unsigned n;
      n = pixels_cfg;
      if (n == 0) n = 1;
      if (n > MAX_PIXELS) n = MAX_PIXELS;
      return n;
   endfunction

   function automatic logic line_now();
      logic        bit_val;
      int unsigned high;
      if (!sending) return 1'b0;
      bit_val = grb_word[23 - bit_pos];
      high = bit_val ? one_high_cfg : zero_high_cfg;
      return (tick_pos < high);
   endfunction

   function automatic void report(input string what);
      if (mismatch_count < REPORT_LIMIT) $display("%0t: %s", $time, what);
      mismatch_count++;
   endfunction

   // one item: a write while idle loads a new word, anything else is a clock tick
   task automatic take_item(input rlcs_pkg::func_type f, input logic [7:0] r, g, b);
      line_sample_type s;
      if (f == rlcs_pkg::FUNC_WRITE && !sending) begin
         grb_word  = {dim(g), dim(r), dim(b)};
         bit_pos   = 0;
         tick_pos  = 0;
         pixel_pos = 0;
         sending   = 1'b1;
         chains_started++;
      end else if (sending) begin
         // a zero period compares like a period of one
         if (tick_pos + 1 >= period_cfg) begin
            tick_pos = 0;
            bit_pos++;
            if (bit_pos >= 24) begin
               bit_pos = 0;
               pixel_pos++;
               if (pixel_pos >= chain_len()) begin
                  pixel_pos = 0;
                  sending   = 1'b0;
               end
            end
         end else begin
            tick_pos++;
         end
      end
      s.level = line_now();
      s.busy  = sending;
      line_queue.push_back(s);
   endtask

   always @(posedge clock) begin
      line_sample_type want;
      if (reset) begin
         period_cfg    = rlcs_pkg::BIT_PERIOD_RST;
         zero_high_cfg = rlcs_pkg::ZERO_HIGH_RST;
         one_high_cfg  = rlcs_pkg::ONE_HIGH_RST;
         bright_cfg    = rlcs_pkg::BRIGHT_RST;
         pixels_cfg    = 11'd1;
         grb_word      = '0;
         bit_pos       = 0;
         tick_pos      = 0;
         pixel_pos     = 0;
         sending       = 1'b0;
         line_queue.delete();
      end else begin
         // results first, so an item never meets its own expectation early
         if (rsp_valid && rsp_ready) begin
            if (line_queue.size() == 0) begin
               report($sformatf("result with nothing expected: line %0b busy %0b",
                                rsp_line_level, rsp_busy_res));
            end else begin
               want = line_queue.pop_front();
               if (rsp_line_level !== want.level)
                  report($sformatf("line_level expected %0b got %0b",
                                   want.level, rsp_line_level));
               if (rsp_busy_res !== want.busy)
                  report($sformatf("busy_res expected %0b got %0b",
                                   want.busy, rsp_busy_res));
            end
         end

         if (req_valid && req_ready)
            take_item(rlcs_pkg::func_type'(req_func), req_red, req_green, req_blue);

         // register writes; spare indexes are ignored
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rlcs_pkg::REG_BIT_PERIOD: period_cfg    = csr_data;
               rlcs_pkg::REG_ZERO_HIGH:  zero_high_cfg = csr_data;
               rlcs_pkg::REG_ONE_HIGH:   one_high_cfg  = csr_data;
               rlcs_pkg::REG_BRIGHTNESS: bright_cfg    = csr_data[7:0];
               rlcs_pkg::REG_PIXEL_CNT:  pixels_cfg    = csr_data[10:0];
               default: ;
            endcase
         end
      end
      pending_results = line_queue.size();
   end

endmodule

>>> sim/tb.sv
// tb: stimulus and verdict for the RGB LED chain serializer.
// Depends on rlcs_pkg, rgb_led_chain_serializer and rlcs_checker.
`timescale 1ns / 1ps

module tb;

   localparam int CHAIN_MAX     = 1024;
   localparam int HOLD_CYCLES   = 48;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RESET_TICKS   = 96;
   localparam int LONG_TICKS    = 30;
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_ITEMS   = 40;
   localparam int FINAL_ITEMS   = 100;
   localparam logic [2:0] FIRST_SPARE_REG = rlcs_pkg::REG_PIXEL_CNT + 3'd1;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_func;
   logic [7:0]  req_red;
   logic [7:0]  req_green;
   logic [7:0]  req_blue;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_line_level;
   logic        rsp_busy_res;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   int          mismatch_count;
   int          pending_results;
   int          chains_started;

   int          sent_count;
   int          rsp_count;
   int          color_writes;
   int          reg_writes;
   int          settings_used;
   int          hold_asks;
   int          holds_done;
   int unsigned cycle_count;
   logic        chain_busy = 1'b0;
   logic        quiet = 1'b0;

   always #1 clock = ~clock;

   rgb_led_chain_serializer #(.MAX_PIXELS(CHAIN_MAX)) dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_func, .req_red, .req_green, .req_blue,
      .rsp_valid, .rsp_ready, .rsp_line_level, .rsp_busy_res,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   rlcs_checker #(.MAX_PIXELS(CHAIN_MAX)) line_check (
      .clock, .reset,
      .req_valid, .req_ready, .req_func, .req_red, .req_green, .req_blue,
      .rsp_valid, .rsp_ready, .rsp_line_level, .rsp_busy_res,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .mismatch_count, .pending_results, .chains_started
   );

   // result side: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      int gap;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != holds_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            holds_done++;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            rsp_ready <= 1'b0;
            repeat (gap - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // count delivered results and remember the last busy flag
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count  <= rsp_count + 1;
         chain_busy <= rsp_busy_res;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rgb_led_chain_serializer test failed");
         $finish;
      end
   end

   task automatic send_item(input rlcs_pkg::func_type f, input logic [7:0] r, g, b);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      if (f == rlcs_pkg::FUNC_WRITE) color_writes++;
   endtask

   // n items with random colors; about one in write_odds is a color write
   task automatic run_items(input int n, input int write_odds);
      rlcs_pkg::func_type f;
      repeat (n) begin
         f = (write_odds != 0 && $urandom_range(1, write_odds) == 1) ?
             rlcs_pkg::FUNC_WRITE : rlcs_pkg::FUNC_TICK;
         send_item(f, 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (rsp_count != sent_count);
   endtask

   // tick until the chain has gone idle and every result is in
   task automatic finish_chain();
      wait_results();
      while (chain_busy) run_items(1, 0);
      wait_results();
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      reg_writes++;
   endtask

   // end a long chain early: one-tick bits and a one-pixel chain, then drain
   task automatic cut_chain();
      wait_results();
      write_reg(rlcs_pkg::REG_BIT_PERIOD, 16'd1);
      write_reg(rlcs_pkg::REG_PIXEL_CNT, 16'd1);
      finish_chain();
   endtask

   // all five registers, plus one write to a spare index that must do nothing
   task automatic set_timing(input logic [15:0] period, zero_high, one_high,
                             input logic [15:0] bright, pixels);
      write_reg(FIRST_SPARE_REG + 3'($urandom_range(0, 2)), 16'($urandom));
      write_reg(rlcs_pkg::REG_BIT_PERIOD, period);
      write_reg(rlcs_pkg::REG_ZERO_HIGH, zero_high);
      write_reg(rlcs_pkg::REG_ONE_HIGH, one_high);
      write_reg(rlcs_pkg::REG_BRIGHTNESS, bright);
      write_reg(rlcs_pkg::REG_PIXEL_CNT, pixels);
      settings_used++;
   endtask

   initial begin : stimulus
      int unsigned period;
      logic [15:0] bright;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_func  <= rlcs_pkg::FUNC_TICK;
      req_red   <= '0;
      req_green <= '0;
      req_blue  <= '0;
      csr_valid <= 1'b0;
      csr_index <= rlcs_pkg::REG_BIT_PERIOD;
      csr_data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset timing, one pixel; second write lands while busy and is dropped;
      // runs past the zero-bit high time, then the chain is cut short
      send_item(rlcs_pkg::FUNC_WRITE, 8'hFF, 8'h00, 8'h80);
      run_items(3, 0);
      send_item(rlcs_pkg::FUNC_WRITE, 8'h00, 8'hFF, 8'h7F);
      run_items(RESET_TICKS, 0);
      cut_chain();
      settings_used++;

      // zero brightness, zero pixel count, zero-high bits stay low
      set_timing(16'd3, 16'd0, 16'd3, 16'd0, 16'd0);
      send_item(rlcs_pkg::FUNC_WRITE, 8'hFF, 8'hFF, 8'hFF);
      run_items(5, 0);
      finish_chain();

      // zero period behaves as a one-tick bit, two pixels
      set_timing(16'd0, 16'd1, 16'd9, 16'd255, 16'd2);
      send_item(rlcs_pkg::FUNC_WRITE, 8'h00, 8'hFF, 8'h00);
      send_item(rlcs_pkg::FUNC_WRITE, 8'h01, 8'h02, 8'h03);
      finish_chain();

      // half brightness, one-bit high time shorter than zero-bit high time
      set_timing(16'd3, 16'd2, 16'd1, 16'd128, 16'd1);
      send_item(rlcs_pkg::FUNC_WRITE, 8'hAA, 8'h55, 8'hFF);
      finish_chain();

      // high times at and past the period keep the line high all bit
      set_timing(16'd2, 16'd3, 16'd2, 16'd255, 16'd1);
      send_item(rlcs_pkg::FUNC_WRITE, 8'hF0, 8'h0F, 8'hA5);
      finish_chain();

      // full-length chains, exact and saturated count, cut short, no idling
      quiet = 1'b1;
      set_timing(16'd1, 16'd1, 16'd1, 16'd255, 16'd1024);
      send_item(rlcs_pkg::FUNC_WRITE, 8'h12, 8'h34, 8'h56);
      run_items(LONG_TICKS, 0);
      cut_chain();
      set_timing(16'd0, 16'd0, 16'd1, 16'd200, 16'd2047);
      send_item(rlcs_pkg::FUNC_WRITE, 8'($urandom), 8'($urandom), 8'($urandom));
      run_items(LONG_TICKS, 0);
      cut_chain();
      quiet = 1'b0;

      // random settings with short chains; the first phase stalls the results
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         period = $urandom_range(0, 4);
         case ($urandom_range(0, 3))
            0:       bright = 16'd0;
            1:       bright = 16'd255;
            default: bright = 16'($urandom);
         endcase
         set_timing(16'(period), 16'($urandom_range(0, period + 1)),
                    16'($urandom_range(0, period + 1)), bright,
                    16'($urandom_range(0, 2)));
         if (p == 0) hold_asks++;
         run_items(PHASE_ITEMS, 6);
         cut_chain();
      end

      // longest bit period, no idling; the run ends mid-bit
      quiet = 1'b1;
      set_timing(16'hFFFF, 16'd0, 16'hFFFF, 16'($urandom), 16'd1024);
      send_item(rlcs_pkg::FUNC_WRITE, 8'($urandom), 8'($urandom), 8'($urandom));
      run_items(FINAL_ITEMS, 10);
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d color writes, %0d chains started) over %0d settings.",
               sent_count, color_writes, chains_started, settings_used);
      $display("Checked %0d results after %0d register writes, with one long result stall.",
               rsp_count, reg_writes);
      if (mismatch_count == 0 && pending_results == 0)
         $display("rgb_led_chain_serializer test passed");
      else
         $display("rgb_led_chain_serializer test failed");
      $finish;
   end

endmodule

>>> files.f
design/rlcs_pkg.sv
design/rlcs_front.sv
design/rlcs_queue.sv
design/rlcs_back.sv
design/rgb_led_chain_serializer.sv
sim/rlcs_checker.sv
sim/tb.sv
